// ----- src/spr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    // Field widths of the streams and the configuration registers.
    localparam int PULSE_W    = 12;
    localparam int SPEED_W    = 10;
    localparam int INTERVAL_W = 16;
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    // Percent times range magnitude: 7 bits by 12 bits.
    localparam int PROD_W = PCT_W + PULSE_W;

    // Division by 100 as a reciprocal multiply: ceil(2^26 / 100). The error stays
    // below 1/100 for every product of PROD_W bits, so the quotient is exact.
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;
    localparam int QUOT_W = PROD_W + RECIP_W - RECIP_SHIFT;

    // Register values after reset.
    localparam logic [PULSE_W-1:0]    MIN_PULSE_RST   = 12'd1100;
    localparam logic [PULSE_W-1:0]    MAX_PULSE_RST   = 12'd1900;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 16'd20;
    localparam logic [PULSE_W-1:0]    DECEL_DIST_RST  = 12'd100;
    localparam logic [SPEED_W-1:0]    ACCEL_STEP_RST  = 10'd1;
    localparam logic [SPEED_W-1:0]    SPEED_LIMIT_RST = 10'd20;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_PULSE   = 3'd0,
        REG_MAX_PULSE   = 3'd1,
        REG_INTERVAL    = 3'd2,
        REG_DECEL_DIST  = 3'd3,
        REG_ACCEL_STEP  = 3'd4,
        REG_SPEED_LIMIT = 3'd5
    } cfg_reg_t;

    // Item kinds carried on s_tuser.
    typedef enum logic {
        OP_TICK       = 1'b0,
        OP_SET_TARGET = 1'b1
    } op_t;

    typedef struct packed {
        logic [PULSE_W-1:0]    min_pulse;
        logic [PULSE_W-1:0]    max_pulse;
        logic [INTERVAL_W-1:0] interval;
        logic [PULSE_W-1:0]    decel_dist;
        logic [SPEED_W-1:0]    accel_step;
        logic [SPEED_W-1:0]    speed_limit;
    } cfg_t;

    // Captured input item, with the percent product already formed.
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [PROD_W-1:0] prod_mag;
        logic              prod_neg;
    } item_t;

    // Motion step result handed to the output register.
    typedef struct packed {
        logic               fire;
        logic [PULSE_W-1:0] pulse;
        logic [SPEED_W-1:0] speed;
    } result_t;

endpackage

`default_nettype wire

// ----- src/spr_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_cfg_regs
    import spr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode one register write; indexes past the list are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_MIN_PULSE:   cfg_next.min_pulse   = cfg_wdata[PULSE_W-1:0];
                REG_MAX_PULSE:   cfg_next.max_pulse   = cfg_wdata[PULSE_W-1:0];
                REG_INTERVAL:    cfg_next.interval    = cfg_wdata[INTERVAL_W-1:0];
                REG_DECEL_DIST:  cfg_next.decel_dist  = cfg_wdata[PULSE_W-1:0];
                REG_ACCEL_STEP:  cfg_next.accel_step  = cfg_wdata[SPEED_W-1:0];
                REG_SPEED_LIMIT: cfg_next.speed_limit = cfg_wdata[SPEED_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse   <= MIN_PULSE_RST;
            cfg_reg.max_pulse   <= MAX_PULSE_RST;
            cfg_reg.interval    <= INTERVAL_RST;
            cfg_reg.decel_dist  <= DECEL_DIST_RST;
            cfg_reg.accel_step  <= ACCEL_STEP_RST;
            cfg_reg.speed_limit <= SPEED_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/spr_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_capture
    import spr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire cfg_t                 cfg,
    input  wire logic                 advance,
    output item_t                     item
);

    logic                      valid_reg;
    logic                      valid_next;
    op_t                       op_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      neg_reg;
    logic signed [PULSE_W:0]   range_diff;
    logic [PULSE_W-1:0]        range_mag;
    logic [PCT_W-1:0]          pct;
    logic                      take;

    // The register frees up when its item moves on in the same cycle.
    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;
    assign pct      = s_tdata[TIME_W +: PCT_W];

    // Signed pulse range and its magnitude for the percent product.
    always_comb begin
        range_diff = signed'({1'b0, cfg.max_pulse}) - signed'({1'b0, cfg.min_pulse});
        if (range_diff[PULSE_W]) begin
            range_mag = PULSE_W'(-range_diff);
        end else begin
            range_mag = range_diff[PULSE_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, including the 7 by 12 bit product.
    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg   <= op_t'(s_tuser);
            now_reg  <= s_tdata[TIME_W-1:0];
            prod_reg <= pct * range_mag;
            neg_reg  <= range_diff[PULSE_W];
        end
    end

    assign item.valid    = valid_reg;
    assign item.op       = op_reg;
    assign item.now      = now_reg;
    assign item.prod_mag = prod_reg;
    assign item.prod_neg = neg_reg;

endmodule

`default_nettype wire

// ----- src/spr_motion.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_motion
    import spr_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  out_free,
    output logic       advance,
    output result_t    result
);

    logic [TIME_W-1:0]  last_step_time_reg;
    logic [PULSE_W-1:0] goal_pulse_reg;
    logic [PULSE_W-1:0] position_pulse_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic [TIME_W-1:0]  last_step_time_next;
    logic [PULSE_W-1:0] goal_pulse_next;
    logic [PULSE_W-1:0] position_pulse_next;
    logic [SPEED_W-1:0] speed_next;

    logic [TIME_W-1:0]           elapsed;
    logic                        step_due;
    logic                        is_tick;
    logic                        is_set;
    logic [PROD_W+RECIP_W-1:0]   recip_prod;
    logic [QUOT_W-1:0]           quot;
    logic signed [PULSE_W+2:0]   quot_s;
    logic signed [PULSE_W+2:0]   goal_raw;
    logic [PULSE_W-1:0]          goal_map;
    logic signed [PULSE_W+1:0]   rem;
    logic signed [PULSE_W+1:0]   dist_s;
    logic [PULSE_W-1:0]          dist_mag;
    logic signed [SPEED_W+1:0]   spd_raw;
    logic [SPEED_W-1:0]          spd_new;
    logic signed [PULSE_W+1:0]   pos_raw;
    logic [PULSE_W-1:0]          pos_new;

    assign is_tick  = item.valid && (item.op == OP_TICK);
    assign is_set   = item.valid && (item.op == OP_SET_TARGET);
    assign elapsed  = item.now - last_step_time_reg;
    assign step_due = elapsed > TIME_W'(cfg.interval);

    // An item moves on unless it has a result and the output is still full.
    assign advance = is_set || (is_tick && (!step_due || out_free));

    // Percent to pulse: divide the product by 100, restore the sign, add the
    // low end of the range and saturate.
    always_comb begin
        recip_prod = item.prod_mag * RECIP_100;
        quot       = recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
        if (item.prod_neg) begin
            quot_s = -signed'((PULSE_W+3)'(quot));
        end else begin
            quot_s = signed'((PULSE_W+3)'(quot));
        end
        goal_raw = signed'((PULSE_W+3)'(cfg.min_pulse)) + quot_s;
        if (goal_raw < 0) begin
            goal_map = '0;
        end else if (goal_raw > signed'((PULSE_W+3)'({PULSE_W{1'b1}}))) begin
            goal_map = '1;
        end else begin
            goal_map = goal_raw[PULSE_W-1:0];
        end
    end

    // Speed update: slow down near the goal, speed up elsewhere, then clamp.
    always_comb begin
        rem      = signed'((PULSE_W+2)'(goal_pulse_reg)) -
                   signed'((PULSE_W+2)'(position_pulse_reg));
        dist_s   = (rem < 0) ? -rem : rem;
        dist_mag = dist_s[PULSE_W-1:0];

        if (dist_mag < cfg.decel_dist) begin
            spd_raw = signed'((SPEED_W+2)'(speed_reg)) -
                      signed'((SPEED_W+2)'(cfg.accel_step));
        end else if (speed_reg < cfg.speed_limit) begin
            spd_raw = signed'((SPEED_W+2)'(speed_reg)) +
                      signed'((SPEED_W+2)'(cfg.accel_step));
        end else begin
            spd_raw = signed'((SPEED_W+2)'(speed_reg));
        end

        if (spd_raw < 0) begin
            spd_new = '0;
        end else if (spd_raw > signed'((SPEED_W+2)'(cfg.speed_limit))) begin
            spd_new = cfg.speed_limit;
        end else begin
            spd_new = spd_raw[SPEED_W-1:0];
        end
    end

    // Position update toward the goal; an overshoot stops at the goal and a
    // zero distance holds the position.
    always_comb begin
        pos_raw = signed'((PULSE_W+2)'(position_pulse_reg));
        pos_new = position_pulse_reg;
        if (rem < 0) begin
            pos_raw = signed'((PULSE_W+2)'(position_pulse_reg)) -
                      signed'((PULSE_W+2)'(spd_new));
            if (pos_raw < signed'((PULSE_W+2)'(goal_pulse_reg))) begin
                pos_new = goal_pulse_reg;
            end else begin
                pos_new = pos_raw[PULSE_W-1:0];
            end
        end else if (rem > 0) begin
            pos_raw = signed'((PULSE_W+2)'(position_pulse_reg)) +
                      signed'((PULSE_W+2)'(spd_new));
            if (pos_raw > signed'((PULSE_W+2)'(goal_pulse_reg))) begin
                pos_new = goal_pulse_reg;
            end else begin
                pos_new = pos_raw[PULSE_W-1:0];
            end
        end
    end

    // State next values and the result handed to the output register.
    always_comb begin
        last_step_time_next = last_step_time_reg;
        goal_pulse_next     = goal_pulse_reg;
        position_pulse_next = position_pulse_reg;
        speed_next          = speed_reg;
        result.fire         = 1'b0;
        result.pulse        = pos_new;
        result.speed        = spd_new;
        if (is_set) begin
            goal_pulse_next = goal_map;
        end else if (is_tick && step_due && out_free) begin
            last_step_time_next = item.now;
            position_pulse_next = pos_new;
            speed_next          = spd_new;
            result.fire         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_step_time_reg <= '0;
            goal_pulse_reg     <= '0;
            position_pulse_reg <= '0;
            speed_reg          <= '0;
        end else begin
            last_step_time_reg <= last_step_time_next;
            goal_pulse_reg     <= goal_pulse_next;
            position_pulse_reg <= position_pulse_next;
            speed_reg          <= speed_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/servo_pulse_ramp_profiler_top.sv -----
// Servo pulse ramp profiler: moves a servo pulse width toward a goal with a
// trapezoidal speed ramp.
// Input stream s_*: s_tuser selects the item kind (0 time tick, 1 set target).
// A set-target transaction maps target_percent onto the configured pulse range
// and stores it as the goal; it gives no result. A tick transaction carries the
// millisecond time; when more than step_interval_ms have passed since the last
// step, one motion step is taken and one result is sent on m_*.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr;
// write only while the block is idle.
// An accepted item waits in the input register, is processed by the update
// stage, and its result is loaded into the output register and shown on m_*.
// Throughput: one transaction per cycle, limited by the single update stage
// that reads and writes the motion state, while no step item is stalled.
// Stalls: the output register holds a result until m_tready takes it; the
// block keeps taking items that give no result, and a step item waits in the
// input register, with s_tready low, until the output can take it.
// Reset: registers return to their default values, the goal, position, speed
// and last step time clear to zero, and both stream sides become empty.
`timescale 1ns / 1ps
`default_nettype none

module servo_pulse_ramp_profiler_top
    import spr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] now_ms, [38:32] target_percent, [39] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [11:0] pulse_width_us, [21:12] speed_now, [23:22] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    advance;
    logic    out_free;

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [PULSE_W-1:0]   pulse_reg;
    logic [SPEED_W-1:0]   speed_now_reg;

    spr_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spr_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .advance  (advance),
        .item     (item)
    );

    spr_motion u_motion (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .cfg      (cfg),
        .out_free (out_free),
        .advance  (advance),
        .result   (result)
    );

    // The output register can load when it is empty or being emptied.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (result.fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.fire) begin
            pulse_reg     <= result.pulse;
            speed_now_reg <= result.speed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-PULSE_W-SPEED_W)'(0), speed_now_reg, pulse_reg};

endmodule

`default_nettype wire

// ----- src/spr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spr_checker
    import spr_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic               have_last_reg;
    logic [PULSE_W-1:0] last_pulse_reg;
    logic               out_take;

    assign out_take = m_tvalid && m_tready;

    // Pulse width of the previous result transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
        end else if (out_take) begin
            have_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            last_pulse_reg <= m_tdata[PULSE_W-1:0];
        end
    end

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With nothing captured after reset, the input side is open.
    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_tready)
        else $error("input not ready after reset");

    // A stalled result holds its data.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The position moves only with a nonzero speed.
    a_move_needs_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take && have_last_reg && (m_tdata[PULSE_W-1:0] != last_pulse_reg)
        |-> (m_tdata[PULSE_W +: SPEED_W] != '0))
        else $error("pulse changed at zero speed");

endmodule

bind servo_pulse_ramp_profiler_top spr_checker u_spr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/tb_servo_pulse_ramp_profiler_top.sv -----
`timescale 1ns / 1ps

module tb_servo_pulse_ramp_profiler_top
    import spr_pkg::*;
();

    // One input item as the sender sees it.
    typedef struct {
        op_t               op;
        logic [TIME_W-1:0] now;
        logic [PCT_W-1:0]  pct;
    } motion_cmd_t;

    // One motion step result.
    typedef struct {
        logic [PULSE_W-1:0] pulse;
        logic [SPEED_W-1:0] speed;
    } pulse_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [31:0] now_ms, [38:32] target_percent, [39] zero
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // [0] operation
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [11:0] pulse_width_us, [21:12] speed_now, [23:22] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Items waiting to be sent and step results still to arrive.
    motion_cmd_t   motion_cmd_q[$];
    pulse_result_t pulse_expect_q[$];
    pulse_result_t want_res;

    // Shadow copy of the registers and the motion state.
    cfg_t               ramp_cfg;
    logic [TIME_W-1:0]  last_step_ms;
    logic [PULSE_W-1:0] goal_us;
    logic [PULSE_W-1:0] pos_us;
    logic [SPEED_W-1:0] speed_us;

    // Millisecond time base for generated ticks.
    logic [TIME_W-1:0] sim_ms;

    int err_count     = 0;
    int send_idle_pct = 13;
    int recv_idle_pct = 47;

    // Long receiver hold-off.
    logic hold_req = 1'b0;
    logic hold_used;
    int   hold_left;

    servo_pulse_ramp_profiler_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Motion predictor: updates the shadow state for one accepted item and
    // queues the result of a tick that steps.
    function automatic void ramp_step(motion_cmd_t cmd);
        logic [TIME_W-1:0] elapsed;
        int lo, hi, pct, mapped;
        int tgt, pos, spd, rem, dist_mag, decel, accel, limit;
        pulse_result_t res;
        if (cmd.op == OP_SET_TARGET) begin
            // Linear map onto the pulse range, quotient truncated toward zero.
            lo = ramp_cfg.min_pulse;
            hi = ramp_cfg.max_pulse;
            pct = cmd.pct;
            mapped = lo + (pct * (hi - lo)) / 100;
            if (mapped < 0) mapped = 0;
            if (mapped > 4095) mapped = 4095;
            goal_us = mapped[PULSE_W-1:0];
            return;
        end
        // Elapsed time wraps with the counter.
        elapsed = cmd.now - last_step_ms;
        if (elapsed <= ramp_cfg.interval) return;
        last_step_ms = cmd.now;

        tgt = goal_us;
        pos = pos_us;
        spd = speed_us;
        decel = ramp_cfg.decel_dist;
        accel = ramp_cfg.accel_step;
        limit = ramp_cfg.speed_limit;
        rem = tgt - pos;
        dist_mag = (rem < 0) ? -rem : rem;

        // Slow down near the goal, otherwise speed up to the limit.
        if (dist_mag < decel) begin
            spd -= accel;
        end else if (spd < limit) begin
            spd += accel;
        end
        if (spd < 0) spd = 0;
        if (spd > limit) spd = limit;

        // Move toward the goal without passing it; hold when already there.
        if (rem < 0) begin
            pos -= spd;
            if (pos < tgt) pos = tgt;
        end else if (rem > 0) begin
            pos += spd;
            if (pos > tgt) pos = tgt;
        end
        pos_us = pos[PULSE_W-1:0];
        speed_us = spd[SPEED_W-1:0];
        res.pulse = pos_us;
        res.speed = speed_us;
        pulse_expect_q.push_back(res);
    endfunction

    function automatic void push_cmd(op_t op, logic [TIME_W-1:0] now, logic [PCT_W-1:0] pct);
        motion_cmd_t cmd;
        cmd.op = op;
        cmd.now = now;
        cmd.pct = pct;
        motion_cmd_q.push_back(cmd);
    endfunction

    // Register write; the shadow copy follows the same masking as the block.
    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_PULSE:   ramp_cfg.min_pulse = val[PULSE_W-1:0];
            REG_MAX_PULSE:   ramp_cfg.max_pulse = val[PULSE_W-1:0];
            REG_INTERVAL:    ramp_cfg.interval = val[INTERVAL_W-1:0];
            REG_DECEL_DIST:  ramp_cfg.decel_dist = val[PULSE_W-1:0];
            REG_ACCEL_STEP:  ramp_cfg.accel_step = val[SPEED_W-1:0];
            REG_SPEED_LIMIT: ramp_cfg.speed_limit = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_profile(int min_p, int max_p, int interval, int decel, int accel,
                               int limit);
        cfg_write(REG_MIN_PULSE, CFG_DATA_W'(min_p));
        cfg_write(REG_MAX_PULSE, CFG_DATA_W'(max_p));
        cfg_write(REG_INTERVAL, CFG_DATA_W'(interval));
        cfg_write(REG_DECEL_DIST, CFG_DATA_W'(decel));
        cfg_write(REG_ACCEL_STEP, CFG_DATA_W'(accel));
        cfg_write(REG_SPEED_LIMIT, CFG_DATA_W'(limit));
    endtask

    // Wait until all items are taken and all results are back, then let
    // the pipeline empty out for ticks that gave no result.
    task automatic wait_drained();
        while (motion_cmd_q.size() != 0 || pulse_expect_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Mostly ticks that step just past the interval, with some early
    // ticks, long gaps, target changes and ticks at random times.
    task automatic gen_motion(int n);
        int r;
        logic [TIME_W-1:0] step;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                push_cmd(OP_SET_TARGET, $urandom(),
                         PCT_W'(($urandom_range(9) == 0) ? $urandom_range(101, 127)
                                                         : $urandom_range(0, 100)));
            end else if (r < 12) begin
                push_cmd(OP_TICK, $urandom(), PCT_W'($urandom_range(0, 127)));
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    step = ramp_cfg.interval + 1 + $urandom_range(0, 3);
                end else if (r < 90) begin
                    step = $urandom_range(0, ramp_cfg.interval);
                end else begin
                    step = ramp_cfg.interval + 1 + $urandom_range(0, 5000);
                end
                sim_ms = sim_ms + step;
                push_cmd(OP_TICK, sim_ms, PCT_W'($urandom_range(0, 127)));
            end
        end
    endtask

    // Input driver: holds an offered transaction until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                ramp_step(motion_cmd_q[0]);
                void'(motion_cmd_q.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (motion_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, motion_cmd_q[0].pct, motion_cmd_q[0].now};
                    s_tuser <= motion_cmd_q[0].op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the long receiver stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_left <= 400;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pulse_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pulse %0d speed %0d",
                                              m_tdata[11:0], m_tdata[21:12]));
                end else begin
                    want_res = pulse_expect_q.pop_front();
                    if (m_tdata[11:0] != want_res.pulse) begin
                        report_mismatch($sformatf("pulse_width_us got %0d expected %0d",
                                                  m_tdata[11:0], want_res.pulse));
                    end
                    if (m_tdata[21:12] != want_res.speed) begin
                        report_mismatch($sformatf("speed_now got %0d expected %0d",
                                                  m_tdata[21:12], want_res.speed));
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run limit.
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        int guard;
        ramp_cfg.min_pulse = MIN_PULSE_RST;
        ramp_cfg.max_pulse = MAX_PULSE_RST;
        ramp_cfg.interval = INTERVAL_RST;
        ramp_cfg.decel_dist = DECEL_DIST_RST;
        ramp_cfg.accel_step = ACCEL_STEP_RST;
        ramp_cfg.speed_limit = SPEED_LIMIT_RST;
        last_step_ms = '0;
        goal_us = '0;
        pos_us = '0;
        speed_us = '0;
        sim_ms = 32'd200;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed items at the reset settings.
        push_cmd(OP_TICK, 32'd0, 7'd127);             // no time passed
        push_cmd(OP_TICK, 32'd20, 7'd0);              // exactly the interval
        push_cmd(OP_TICK, 32'd21, 7'd0);              // step at zero distance
        push_cmd(OP_SET_TARGET, 32'hFFFF_FFFF, 7'd100);
        push_cmd(OP_TICK, 32'd42, 7'd0);
        push_cmd(OP_TICK, 32'd63, 7'd0);
        push_cmd(OP_TICK, 32'd84, 7'd0);
        push_cmd(OP_SET_TARGET, 32'd0, 7'd127);       // beyond one hundred percent
        push_cmd(OP_TICK, 32'd105, 7'd0);
        push_cmd(OP_SET_TARGET, 32'd0, 7'd0);
        push_cmd(OP_TICK, 32'hFFFF_FFFF, 7'd0);       // large jump
        push_cmd(OP_TICK, 32'd20, 7'd0);              // wraps, 21 ms
        push_cmd(OP_TICK, 32'd21, 7'd0);              // only 1 ms
        push_cmd(OP_TICK, 32'd200, 7'd0);
        gen_motion(180);
        wait_drained();

        // Widest range, zero interval, largest steps; time wraps soon.
        set_profile(0, 4095, 0, 4095, 1023, 1023);
        sim_ms = 32'hFFFF_FF00;
        gen_motion(190);
        wait_drained();

        // Reversed range, longest interval, no deceleration zone.
        set_profile(4095, 0, 65535, 0, 3, 40);
        sim_ms = 32'hFFF0_0000;
        gen_motion(190);
        wait_drained();

        // Speed limit zero: the position must hold.
        send_idle_pct = 47;
        recv_idle_pct = 13;
        set_profile(500, 2500, 5, 200, 7, 0);
        sim_ms = $urandom();
        gen_motion(190);
        wait_drained();

        // No acceleration and a narrow range.
        set_profile(1000, 1010, 2, 50, 0, 30);
        gen_motion(190);
        wait_drained();

        // Random settings with a long receiver stall.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_profile($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 30),
                    $urandom_range(0, 800), $urandom_range(1, 60), $urandom_range(1, 300));
        @(posedge aclk);
        hold_req <= 1'b1;
        gen_motion(190);
        wait_drained();

        set_profile($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 30),
                    $urandom_range(0, 800), $urandom_range(1, 60), $urandom_range(1, 300));
        gen_motion(190);

        // Final drain with a bound.
        guard = 0;
        while ((motion_cmd_q.size() != 0 || pulse_expect_q.size() != 0) && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        while (pulse_expect_q.size() != 0) begin
            want_res = pulse_expect_q.pop_front();
            report_mismatch($sformatf("missing result pulse %0d speed %0d",
                                      want_res.pulse, want_res.speed));
        end
        if (motion_cmd_q.size() != 0) begin
            report_mismatch($sformatf("%0d items never accepted", motion_cmd_q.size()));
        end

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
